[sv/assert_macros.svh]
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define CHK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ple_pkg.sv]
// Shared constants, codes and control types for the positional list engine.
`timescale 1ns / 1ps

package ple_pkg;

    localparam int CAPACITY_DEF = 16;

    // Input mode codes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_DUMP   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BADPOS   = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // Datapath operation codes, one per cycle
    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_INS_PRIME = 4'd2;
    localparam logic [3:0] OP_INS_SHIFT = 4'd3;
    localparam logic [3:0] OP_INS_PUT   = 4'd4;
    localparam logic [3:0] OP_RM_PRIME  = 4'd5;
    localparam logic [3:0] OP_RM_SEARCH = 4'd6;
    localparam logic [3:0] OP_RM_SHIFT  = 4'd7;
    localparam logic [3:0] OP_RM_DROP   = 4'd8;
    localparam logic [3:0] OP_HEAD_RD   = 4'd9;
    localparam logic [3:0] OP_TAIL_RD   = 4'd10;
    localparam logic [3:0] OP_TAIL_CAP  = 4'd11;
    localparam logic [3:0] OP_RES_OUT   = 4'd12;
    localparam logic [3:0] OP_DUMP_RD   = 4'd13;
    localparam logic [3:0] OP_DUMP_OUT  = 4'd14;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] res_status;
    } ple_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       pos_bad;
        logic       full;
        logic       empty;
        logic       ins_shift;
        logic       ins_more;
        logic       match;
        logic       at_tail;
        logic       shift_more;
        logic       out_free;
    } ple_sts_t;

endpackage

[sv/ple_datapath.sv]
// Datapath: entry memory, count, walk index, head/tail values and result register.
`timescale 1ns / 1ps

module ple_datapath
    import ple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ple_cmd_t           cmd,
    output ple_sts_t           sts,
    input  logic [1:0]         mode,
    input  logic signed [31:0] value,
    input  logic [7:0]         position,
    input  logic               out_stall,
    output logic               out_valid,
    output logic [2:0]         status,
    output logic [4:0]         entry_position,
    output logic signed [31:0] entry_value,
    output logic signed [31:0] first_value,
    output logic signed [31:0] last_value,
    output logic [4:0]         entry_count,
    output logic               is_last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > 8) ? CW : 8) + 1;

    logic [31:0] mem [CAPACITY];

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ix_reg, ix_next;
    logic [1:0]    mode_reg;
    logic [31:0]   val_reg;
    logic [7:0]    pos_reg;
    logic [31:0]   rdata_reg;
    logic [31:0]   first_reg, first_next;
    logic [31:0]   last_reg, last_next;

    logic          ov_reg, ov_next;
    logic [2:0]    ost_reg;
    logic [4:0]    opos_reg;
    logic [31:0]   oval_reg;
    logic [31:0]   ofirst_reg;
    logic [31:0]   olast_reg;
    logic [4:0]    ocnt_reg;
    logic          olast_flag_reg;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [31:0]   wr_data;

    logic [CW-1:0] cnt_m1, ix_m1, ix_m2, ix_p1, ix_p2;
    logic [PW-1:0] pos_w, pos_m1, cnt_w;

    assign cnt_m1 = count_reg - CW'(1);
    assign ix_m1  = ix_reg - CW'(1);
    assign ix_m2  = ix_reg - CW'(2);
    assign ix_p1  = ix_reg + CW'(1);
    assign ix_p2  = ix_reg + CW'(2);
    assign pos_w  = PW'(pos_reg);
    assign pos_m1 = pos_w - PW'(1);
    assign cnt_w  = PW'(count_reg);

    // status back to the controller
    assign sts.mode       = mode_reg;
    assign sts.pos_bad    = (pos_reg == 8'd0) || (pos_w > cnt_w + PW'(1));
    assign sts.full       = (count_reg == CW'(CAPACITY));
    assign sts.empty      = (count_reg == '0);
    assign sts.ins_shift  = (pos_w <= cnt_w);
    assign sts.ins_more   = (PW'(ix_reg) > pos_w);
    assign sts.match      = (rdata_reg == val_reg);
    assign sts.at_tail    = (ix_p1 == count_reg);
    assign sts.shift_more = (ix_p2 < count_reg);
    assign sts.out_free   = !ov_reg || !out_stall;

    // memory port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rdata_reg;
        unique case (cmd.op)
            OP_INS_PRIME:
            begin
                rd_en   = 1'b1;
                rd_addr = cnt_m1[AW-1:0];
            end
            OP_INS_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = ix_reg[AW-1:0];
                rd_en   = sts.ins_more;
                rd_addr = ix_m2[AW-1:0];
            end
            OP_INS_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_m1[AW-1:0];
                wr_data = val_reg;
            end
            OP_RM_PRIME:
            begin
                rd_en   = 1'b1;
            end
            OP_RM_SEARCH:
            begin
                rd_en   = !sts.at_tail;
                rd_addr = ix_p1[AW-1:0];
            end
            OP_RM_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = ix_reg[AW-1:0];
                rd_en   = sts.shift_more;
                rd_addr = ix_p2[AW-1:0];
            end
            OP_HEAD_RD:
            begin
                rd_en   = !sts.empty;
            end
            OP_TAIL_RD:
            begin
                rd_en   = !sts.empty;
                rd_addr = cnt_m1[AW-1:0];
            end
            OP_DUMP_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = ix_reg[AW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // index, count, head and tail
    always_comb
    begin
        ix_next    = ix_reg;
        count_next = count_reg;
        first_next = first_reg;
        last_next  = last_reg;
        unique case (cmd.op)
            OP_LOAD:      ix_next = '0;
            OP_INS_PRIME: ix_next = count_reg;
            OP_INS_SHIFT: ix_next = ix_m1;
            OP_INS_PUT:   count_next = count_reg + CW'(1);
            OP_RM_SEARCH: ix_next = sts.match ? ix_reg : ix_p1;
            OP_RM_SHIFT:  ix_next = ix_p1;
            OP_RM_DROP:   count_next = cnt_m1;
            OP_TAIL_RD:   first_next = sts.empty ? 32'd0 : rdata_reg;
            OP_TAIL_CAP:  last_next = sts.empty ? 32'd0 : rdata_reg;
            OP_DUMP_OUT:  ix_next = ix_p1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ix_reg    <= '0;
            first_reg <= '0;
            last_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ix_reg    <= ix_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            ov_reg    <= ov_next;
        end
    end

    // item latch
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            mode_reg <= mode;
            val_reg  <= value;
            pos_reg  <= position;
        end
    end

    // result register
    always_comb
    begin
        ov_next = ov_reg && out_stall;
        if (cmd.op == OP_RES_OUT || cmd.op == OP_DUMP_OUT)
        begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_RES_OUT)
        begin
            ost_reg        <= cmd.res_status;
            opos_reg       <= '0;
            oval_reg       <= '0;
            olast_flag_reg <= 1'b1;
        end
        else if (cmd.op == OP_DUMP_OUT)
        begin
            ost_reg        <= ST_OK;
            opos_reg       <= 5'(ix_p1);
            oval_reg       <= rdata_reg;
            olast_flag_reg <= sts.at_tail;
        end
        if (cmd.op == OP_RES_OUT || cmd.op == OP_DUMP_OUT)
        begin
            ofirst_reg <= first_reg;
            olast_reg  <= last_reg;
            ocnt_reg   <= 5'(count_reg);
        end
    end

    assign out_valid      = ov_reg;
    assign status         = ost_reg;
    assign entry_position = opos_reg;
    assign entry_value    = oval_reg;
    assign first_value    = ofirst_reg;
    assign last_value     = olast_reg;
    assign entry_count    = ocnt_reg;
    assign is_last        = olast_flag_reg;

endmodule

[sv/ple_controller.sv]
// Controller: sequences insert, remove and dump over the datapath.
`timescale 1ns / 1ps

module ple_controller
    import ple_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  ple_sts_t sts,
    output ple_cmd_t cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECIDE    = 4'd1;
    localparam logic [3:0] S_INS_PRIME = 4'd2;
    localparam logic [3:0] S_INS_SHIFT = 4'd3;
    localparam logic [3:0] S_INS_PUT   = 4'd4;
    localparam logic [3:0] S_RM_PRIME  = 4'd5;
    localparam logic [3:0] S_RM_SEARCH = 4'd6;
    localparam logic [3:0] S_RM_SHIFT  = 4'd7;
    localparam logic [3:0] S_RM_DROP   = 4'd8;
    localparam logic [3:0] S_HEAD      = 4'd9;
    localparam logic [3:0] S_TAIL      = 4'd10;
    localparam logic [3:0] S_TAIL_CAP  = 4'd11;
    localparam logic [3:0] S_RESULT    = 4'd12;
    localparam logic [3:0] S_DUMP_RD   = 4'd13;
    localparam logic [3:0] S_DUMP_OUT  = 4'd14;

    logic [3:0] state_reg, state_next;
    logic [2:0] res_reg, res_next;
    logic [3:0] op;

    assign in_stall       = (state_reg != S_IDLE);
    assign cmd.op         = op;
    assign cmd.res_status = res_reg;

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        op         = OP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                res_next = ST_OK;
                priority if (sts.mode == MODE_INSERT)
                begin
                    priority if (sts.pos_bad)
                    begin
                        res_next   = ST_BADPOS;
                        state_next = S_RESULT;
                    end
                    else if (sts.full)
                    begin
                        res_next   = ST_FULL;
                        state_next = S_RESULT;
                    end
                    else if (sts.ins_shift)
                    begin
                        state_next = S_INS_PRIME;
                    end
                    else
                    begin
                        state_next = S_INS_PUT;
                    end
                end
                else if (sts.mode == MODE_REMOVE)
                begin
                    if (sts.empty)
                    begin
                        res_next   = ST_EMPTY;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_RM_PRIME;
                    end
                end
                else if (sts.mode == MODE_DUMP)
                begin
                    if (sts.empty)
                    begin
                        res_next   = ST_EMPTY;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_DUMP_RD;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_INS_PRIME:
            begin
                op         = OP_INS_PRIME;
                state_next = S_INS_SHIFT;
            end
            S_INS_SHIFT:
            begin
                op = OP_INS_SHIFT;
                if (!sts.ins_more)
                begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT:
            begin
                op         = OP_INS_PUT;
                state_next = S_HEAD;
            end
            S_RM_PRIME:
            begin
                op         = OP_RM_PRIME;
                state_next = S_RM_SEARCH;
            end
            S_RM_SEARCH:
            begin
                op = OP_RM_SEARCH;
                priority if (sts.match && !sts.at_tail)
                begin
                    state_next = S_RM_SHIFT;
                end
                else if (sts.match)
                begin
                    state_next = S_RM_DROP;
                end
                else if (sts.at_tail)
                begin
                    res_next   = ST_NOTFOUND;
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_RM_SEARCH;
                end
            end
            S_RM_SHIFT:
            begin
                op = OP_RM_SHIFT;
                if (!sts.shift_more)
                begin
                    state_next = S_RM_DROP;
                end
            end
            S_RM_DROP:
            begin
                op         = OP_RM_DROP;
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                op         = OP_HEAD_RD;
                state_next = S_TAIL;
            end
            S_TAIL:
            begin
                op         = OP_TAIL_RD;
                state_next = S_TAIL_CAP;
            end
            S_TAIL_CAP:
            begin
                op         = OP_TAIL_CAP;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    op         = OP_RES_OUT;
                    state_next = S_IDLE;
                end
            end
            S_DUMP_RD:
            begin
                op         = OP_DUMP_RD;
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                if (sts.out_free)
                begin
                    op         = OP_DUMP_OUT;
                    state_next = sts.at_tail ? S_IDLE : S_DUMP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

endmodule

[sv/positional_list_engine.sv]
// Top level of the positional list engine: controller plus datapath.
`timescale 1ns / 1ps

// Ordered store of up to CAPACITY signed 32-bit values, packed in list order.
// Input channel (in_valid/in_stall): one beat per command, mode/value/position.
//   mode 0 inserts value at 1-based position, 1 removes first equal value,
//   2 dumps every entry, 3 is dropped with no result.
// Output channel (out_valid/out_stall): insert and remove give one beat with
//   status, count and head/tail values; a dump gives one beat per entry, or a
//   single empty-status beat, with is_last on the final beat.
// Steps (n = entries held, p = position):
//   insert : move entries p..n back one place, write the value, read head
//            and tail; appending at p = n + 1 moves none
//   remove : search from the head, move later entries forward, drop the
//            tail, read head and tail; not found ends at the tail
//   dump   : read, then load each entry; errors go straight to the result
// One command is in flight at a time; in_stall is low only when idle, but a
// finished result may still sit in the output register while the next beat
// is taken. When the receiver stalls, the output beat holds and the engine
// waits before loading the next one. Reset clears the count and the output
// valid; memory contents are not cleared and need no clearing pass.
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic signed [31:0] value,
    input  logic [7:0]         position,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [4:0]         entry_position,
    output logic signed [31:0] entry_value,
    output logic signed [31:0] first_value,
    output logic signed [31:0] last_value,
    output logic [4:0]         entry_count,
    output logic               is_last
);

    ple_cmd_t cmd;
    ple_sts_t sts;

    // sequencing of each command
    ple_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // storage, walk index and result register
    ple_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .mode           (mode),
        .value          (value),
        .position       (position),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .status         (status),
        .entry_position (entry_position),
        .entry_value    (entry_value),
        .first_value    (first_value),
        .last_value     (last_value),
        .entry_count    (entry_count),
        .is_last        (is_last)
    );

endmodule

[sv/ple_checker.sv]
// Port-level checker for the positional list engine, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ple_checker
    import ple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic [2:0]         status,
    input logic [4:0]         entry_position,
    input logic signed [31:0] entry_value,
    input logic signed [31:0] first_value,
    input logic signed [31:0] last_value,
    input logic [4:0]         entry_count,
    input logic               is_last
);

    `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(entry_position) && $stable(entry_value) && $stable(is_last), "stalled output beat changed")
    `CHK_IMPL(a_empty_ends, out_valid && entry_count == 5'd0, first_value == 32'sd0 && last_value == 32'sd0, "empty store shows a head or tail value")
    `CHK_IMPL(a_err_single, out_valid && status != ST_OK, is_last && entry_position == 5'd0, "error beat not single or carries a position")
    `CHK_IMPL(a_dump_tail, out_valid && entry_position != 5'd0 && is_last, entry_position == entry_count, "last dumped entry is not at the tail")
    `CHK_IMPL(a_count_cap, out_valid, entry_count <= CAPACITY, "count above capacity")

endmodule

bind positional_list_engine ple_checker #(
    .CAPACITY (CAPACITY)
) u_ple_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .entry_position (entry_position),
    .entry_value    (entry_value),
    .first_value    (first_value),
    .last_value     (last_value),
    .entry_count    (entry_count),
    .is_last        (is_last)
);

[tb/positional_list_engine_test.sv]
// Self-checking testbench for the positional list engine: directed cases, then random traffic.
`timescale 1ns / 1ps

module positional_list_engine_test;
    import ple_pkg::*;

    localparam int LIST_DEPTH  = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 500000;
    // A dump of a full store is the slowest command.
    localparam int SETTLE_CYCLES = 2 * LIST_DEPTH + 16;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    // One output beat as the engine should present it.
    typedef struct packed {
        logic [2:0]         status;
        logic [4:0]         entry_position;
        logic signed [31:0] entry_value;
        logic signed [31:0] first_value;
        logic signed [31:0] last_value;
        logic [4:0]         entry_count;
        logic               is_last;
    } list_beat_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         mode = MODE_INSERT;
    logic signed [31:0] value = '0;
    logic [7:0]         position = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         status;
    logic [4:0]         entry_position;
    logic signed [31:0] entry_value;
    logic signed [31:0] first_value;
    logic signed [31:0] last_value;
    logic [4:0]         entry_count;
    logic               is_last;

    // Shadow copy of the list, kept packed in list order.
    logic signed [31:0] shadow_store [LIST_DEPTH];
    int                 shadow_count = 0;
    list_beat_t         pending_beats [$];

    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;
    int mismatches    = 0;
    int commands_sent = 0;
    int beats_checked = 0;
    int cycle_count   = 0;

    positional_list_engine #(.CAPACITY(LIST_DEPTH)) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .value          (value),
        .position       (position),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .entry_position (entry_position),
        .entry_value    (entry_value),
        .first_value    (first_value),
        .last_value     (last_value),
        .entry_count    (entry_count),
        .is_last        (is_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, pending_beats.size());
            $display("positional_list_engine_test NOT OK");
            $finish;
        end
    end

    // Receiver back-pressure, changed on the falling edge only.
    always @(negedge clk)
        out_stall = ($urandom_range(99) < receiver_stall_pct);

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("beat %0d %s: got %0h, want %0h",
                                   beats_checked, name, got, want));
    endtask

    // Head and tail are taken from the shadow after the operation.
    function automatic list_beat_t make_beat(input logic [2:0] st, input int pos,
                                             input logic signed [31:0] val,
                                             input logic last);
        list_beat_t b;
        b.status         = st;
        b.entry_position = pos[4:0];
        b.entry_value    = val;
        b.first_value    = (shadow_count != 0) ? shadow_store[0] : '0;
        b.last_value     = (shadow_count != 0) ? shadow_store[shadow_count - 1] : '0;
        b.entry_count    = shadow_count[4:0];
        b.is_last        = last;
        return b;
    endfunction

    // Applies one accepted command to the shadow list and queues its beats.
    task automatic predict_list_op(input logic [1:0] m, input logic signed [31:0] v,
                                   input logic [7:0] p);
        int i;
        int hit;
        case (m)
            MODE_INSERT:
            begin
                if (p == 0 || int'(p) > shadow_count + 1)
                    pending_beats.push_back(make_beat(ST_BADPOS, 0, '0, 1'b1));
                else if (shadow_count >= LIST_DEPTH)
                    pending_beats.push_back(make_beat(ST_FULL, 0, '0, 1'b1));
                else
                begin
                    for (i = shadow_count; i >= int'(p); i--)
                        shadow_store[i] = shadow_store[i - 1];
                    shadow_store[p - 1] = v;
                    shadow_count++;
                    pending_beats.push_back(make_beat(ST_OK, 0, '0, 1'b1));
                end
            end
            MODE_REMOVE:
            begin
                hit = -1;
                for (i = 0; i < shadow_count && hit < 0; i++)
                    if (shadow_store[i] == v)
                        hit = i;
                if (shadow_count == 0)
                    pending_beats.push_back(make_beat(ST_EMPTY, 0, '0, 1'b1));
                else if (hit < 0)
                    pending_beats.push_back(make_beat(ST_NOTFOUND, 0, '0, 1'b1));
                else
                begin
                    for (i = hit; i + 1 < shadow_count; i++)
                        shadow_store[i] = shadow_store[i + 1];
                    shadow_count--;
                    pending_beats.push_back(make_beat(ST_OK, 0, '0, 1'b1));
                end
            end
            MODE_DUMP:
            begin
                if (shadow_count == 0)
                    pending_beats.push_back(make_beat(ST_EMPTY, 0, '0, 1'b1));
                else
                    for (i = 0; i < shadow_count; i++)
                        pending_beats.push_back(make_beat(ST_OK, i + 1, shadow_store[i],
                                                          i + 1 == shadow_count));
            end
            default: ;  // unused mode: dropped, no beat
        endcase
    endtask

    // Result checker: every beat taken is matched against the oldest prediction.
    always @(posedge clk)
    begin
        list_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_beats.size() == 0)
                report_error($sformatf("unexpected beat, status %0d count %0d",
                                       status, entry_count));
            else
            begin
                want = pending_beats.pop_front();
                check_field("status", 32'(status), 32'(want.status));
                check_field("entry_position", 32'(entry_position),
                            32'(want.entry_position));
                check_field("entry_value", entry_value, want.entry_value);
                check_field("first_value", first_value, want.first_value);
                check_field("last_value", last_value, want.last_value);
                check_field("entry_count", 32'(entry_count), 32'(want.entry_count));
                check_field("is_last", 32'(is_last), 32'(want.is_last));
            end
            beats_checked++;
        end
    end

    // Sends one command beat; entered and left on a falling edge.
    task automatic send_command(input logic [1:0] m, input logic signed [31:0] v,
                                input logic [7:0] p);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        mode     = m;
        value    = v;
        position = p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_list_op(m, v, p);
        commands_sent++;
        @(negedge clk);
    endtask

    // Holds the sender off until every predicted beat has come back.
    task automatic drain_results();
        in_valid = 1'b0;
        while (pending_beats.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return $urandom;
        else if (r < 80)
            return $urandom_range(7);      // small pool, so duplicates turn up
        else
            case ($urandom_range(3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return 32'sd0;
                default: return -32'sd1;
            endcase
    endfunction

    task automatic test_empty_store();
        send_command(MODE_REMOVE, 32'sd5, 8'd0);     // remove from empty
        send_command(MODE_DUMP, 32'sd0, 8'd0);       // dump of empty store
        send_command(MODE_INSERT, 32'sd1, 8'd0);     // position zero
        send_command(MODE_INSERT, 32'sd1, 8'd2);     // past count plus one
        send_command(MODE_UNUSED, $urandom, 8'($urandom));  // no beat
    endtask

    task automatic test_insert_positions();
        send_command(MODE_INSERT, VAL_MAX, 8'd1);
        send_command(MODE_INSERT, VAL_MIN, 8'd2);    // at the tail
        send_command(MODE_INSERT, 32'sd0, 8'd1);     // at the head
        send_command(MODE_INSERT, -32'sd1, 8'd2);    // in the middle
        send_command(MODE_INSERT, 32'sd9, 8'd255);   // top position code
        send_command(MODE_DUMP, 32'sd0, 8'd0);
    endtask

    task automatic test_full_store();
        int n;
        for (n = 0; shadow_count < LIST_DEPTH; n++)
            send_command(MODE_INSERT, (n % 3 == 0) ? 32'sd7 : $urandom,
                         8'((n % 2 == 0) ? shadow_count + 1 : (shadow_count + 1) / 2));
        // Valid position on a full store reports full; one further is a bad position.
        send_command(MODE_INSERT, 32'sd3, 8'(LIST_DEPTH + 1));
        send_command(MODE_INSERT, 32'sd3, 8'(LIST_DEPTH + 2));
        send_command(MODE_DUMP, 32'sd0, 8'd0);
    endtask

    task automatic test_remove_cases();
        send_command(MODE_REMOVE, 32'sd123456, 8'd0);              // absent value
        send_command(MODE_REMOVE, shadow_store[0], 8'd0);           // head
        send_command(MODE_REMOVE, shadow_store[shadow_count - 1], 8'd0);  // tail
        send_command(MODE_REMOVE, 32'sd7, 8'd0);                    // first of duplicates
        send_command(MODE_DUMP, 32'sd0, 8'd0);
    endtask

    // Mostly well-formed commands; ins_pct steers the fill level.
    task automatic test_random_traffic(input int items, input int ins_pct,
                                       input int idle_pct, input int stall_pct,
                                       input bit hold_off);
        int n;
        int r;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (n = 0; n < items; n++)
        begin
            if (hold_off && n % 9 == 8)
                drain_results();
            r = $urandom_range(99);
            if (r < ins_pct)
                send_command(MODE_INSERT, pick_value(),
                             8'($urandom_range(shadow_count + 1, 1)));
            else if (r < 80)
                send_command(MODE_REMOVE,
                             (shadow_count != 0 && $urandom_range(3) != 0)
                                 ? shadow_store[$urandom_range(shadow_count - 1)]
                                 : pick_value(),
                             8'($urandom));
            else if (r < 90)
                send_command(MODE_DUMP, $urandom, 8'($urandom));
            else
                case ($urandom_range(2))
                    0:       send_command(MODE_INSERT, pick_value(), 8'($urandom));
                    1:       send_command(MODE_INSERT, pick_value(), 8'd0);
                    default: send_command(MODE_UNUSED, $urandom, 8'($urandom));
                endcase
        end
        drain_results();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_store();
        test_insert_positions();
        test_full_store();
        test_remove_cases();
        drain_results();

        test_random_traffic(24, 55, 24, 60, 1'b0);
        test_random_traffic(24, 25, 60, 24, 1'b1);
        test_random_traffic(24, 45, 0, 0, 1'b0);

        // Let any trailing work finish, so a stray beat would still be seen.
        in_valid = 1'b0;
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pending_beats.size() != 0)
            report_error($sformatf("%0d beats never arrived", pending_beats.size()));

        $display("Ran %0d commands (insert, remove, dump, bad and unused codes) and checked",
                 commands_sent);
        $display("%0d result beats under three sender/receiver idling mixes.", beats_checked);
        if (mismatches == 0)
            $display("positional_list_engine_test OK");
        else
            $display("positional_list_engine_test NOT OK");
        $finish;
    end

endmodule
